[src/cpqs_pkg.sv]
// Shared constants and types for the closed polyline quad stroker.
package cpqs_pkg;

  localparam int CoordBits = 24;
  localparam int FracBits  = 8;
  localparam int WidthBits = 16;
  localparam int MagBits   = 31;
  localparam int SqBits    = 62;
  localparam int RootBits  = 31;
  localparam int UnitBits  = 15;
  localparam int QuotBits  = 15;
  localparam int ProdBits  = UnitBits + WidthBits;
  localparam int ScaleShift = 23 - FracBits;
  localparam logic [WidthBits-1:0] WidthReset = 16'd768;

  typedef logic signed [CoordBits-1:0] coord_t;

endpackage

[src/closed_polyline_quad_stroker.sv]
// Closed polyline quad stroker: one quad per segment, plus a closing quad.
// A point that ends a segment has its quad computed by a normalize loop, two 31-step squares,
// a 31-step root, two 48-step divisions and two 16-step multiplies, one bit per cycle; a
// zero-length segment goes from the normalize loop straight to the corners. A first point
// is only stored, and a lone final point's quad is valid in the next cycle; the
// input waits until each quad is taken. Synchronous active-high reset clears the state.
module closed_polyline_quad_stroker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cpqs_pkg::WidthBits-1:0]      line_width,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [cpqs_pkg::CoordBits-1:0] point_x,
  input  logic signed [cpqs_pkg::CoordBits-1:0] point_y,
  input  logic                                final_point,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cpqs_pkg::CoordBits-1:0] corner0_x,
  output logic signed [cpqs_pkg::CoordBits-1:0] corner0_y,
  output logic signed [cpqs_pkg::CoordBits-1:0] corner1_x,
  output logic signed [cpqs_pkg::CoordBits-1:0] corner1_y,
  output logic signed [cpqs_pkg::CoordBits-1:0] corner2_x,
  output logic signed [cpqs_pkg::CoordBits-1:0] corner2_y,
  output logic signed [cpqs_pkg::CoordBits-1:0] corner3_x,
  output logic signed [cpqs_pkg::CoordBits-1:0] corner3_y,
  output logic                                last_quad
);

  localparam int CB = cpqs_pkg::CoordBits;
  localparam int MB = cpqs_pkg::MagBits;
  localparam int SB = cpqs_pkg::SqBits;
  localparam int RB = cpqs_pkg::RootBits;
  localparam int UB = cpqs_pkg::UnitBits;
  localparam int WB = cpqs_pkg::WidthBits;
  localparam int PB = cpqs_pkg::ProdBits;
  localparam int SS = cpqs_pkg::ScaleShift;
  localparam int DB = CB + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_SQX, S_SQY, S_ROOT, S_DIVX, S_DIVY, S_MULX, S_MULY,
    S_CORN, S_EMIT1, S_EMIT2
  } state_t;

  state_t state;
  logic [1:0] phase;
  logic [WB-1:0] width_reg;
  cpqs_pkg::coord_t prev_x, prev_y, cur_x, cur_y;
  cpqs_pkg::coord_t first0_x, first0_y, first1_x, first1_y;
  cpqs_pkg::coord_t end2_x, end2_y, end3_x, end3_y;
  logic fin;
  logic neg_x, neg_y;
  logic [MB-1:0] ax, ay;
  logic [SB-1:0] sq_acc, sq_mcand;
  logic [MB-1:0] sq_mplier;
  logic [5:0] cnt;
  logic [SB-1:0] rt_n;
  logic [SB-1:0] rt_r;
  logic [SB-1:0] rt_bit;
  logic [MB+UB:0] dv_num;
  logic [RB+1:0] dv_rem;
  logic [UB-1:0] dv_q, qx;
  logic [PB-1:0] ml_acc;
  logic [WB-1:0] ml_w;
  logic [UB-1:0] ml_a;
  logic [PB-SS:0] ox, oy;

  // Step values for the sequential root, divide and multiply (one bit each cycle), and point deltas.
  logic [SB:0] rt_try;
  logic [RB+1:0] dv_shift;
  logic [RB+1:0] dv_div;
  logic [PB-1:0] ml_sum;
  logic [DB:0] dx_full, dy_full;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign rt_try = {1'b0, rt_n} - ({1'b0, rt_r} + {1'b0, rt_bit});
  assign dv_shift = {dv_rem[RB:0], dv_num[MB+UB]};
  assign dv_div = {1'b0, rt_r[RB:0]};
  assign ml_sum = ml_acc + (ml_w[0] ? ({{(PB-UB){1'b0}}, ml_a} << cnt[3:0]) : '0);
  assign dx_full = {{2{point_x[CB-1]}}, point_x} - {{2{prev_x[CB-1]}}, prev_x};
  assign dy_full = {{2{point_y[CB-1]}}, point_y} - {{2{prev_y[CB-1]}}, prev_y};

  function automatic cpqs_pkg::coord_t sat_add(cpqs_pkg::coord_t p,
                                               logic [PB-SS:0] o,
                                               logic sub);
    logic signed [CB+1:0] s;
    logic signed [CB+1:0] ov;
    begin
      ov = $signed({{(CB+1-(PB-SS)){1'b0}}, o});
      s = sub ? ($signed({{2{p[CB-1]}}, p}) - ov) : ($signed({{2{p[CB-1]}}, p}) + ov);
      if (s > $signed({3'b000, {(CB-1){1'b1}}})) sat_add = {1'b0, {(CB-1){1'b1}}};
      else if (s < $signed({3'b111, {(CB-1){1'b0}}})) sat_add = {1'b1, {(CB-1){1'b0}}};
      else sat_add = s[CB-1:0];
    end
  endfunction

  logic [DB:0] mx, my;
  assign mx = dx_full[DB] ? -dx_full : dx_full;
  assign my = dy_full[DB] ? -dy_full : dy_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 2'd0;
      width_reg <= cpqs_pkg::WidthReset;
      out_valid <= 1'b0;
      prev_x <= '0; prev_y <= '0;
      first0_x <= '0; first0_y <= '0; first1_x <= '0; first1_y <= '0;
      end2_x <= '0; end2_y <= '0; end3_x <= '0; end3_y <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) width_reg <= line_width;
          if (in_valid && in_ready) begin
            cur_x <= point_x; cur_y <= point_y; fin <= final_point;
            if (phase == 2'd0) begin
              if (final_point) begin
                corner0_x <= point_x; corner0_y <= point_y;
                corner1_x <= point_x; corner1_y <= point_y;
                corner2_x <= point_x; corner2_y <= point_y;
                corner3_x <= point_x; corner3_y <= point_y;
                last_quad <= 1'b1; out_valid <= 1'b1;
              end else begin
                prev_x <= point_x; prev_y <= point_y; phase <= 2'd1;
              end
            end else begin
              neg_x <= dx_full[DB]; neg_y <= dy_full[DB];
              ax <= {{(MB-DB){1'b0}}, mx[DB-1:0]};
              ay <= {{(MB-DB){1'b0}}, my[DB-1:0]};
              state <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (ax == '0 && ay == '0) begin
            qx <= '0; ml_acc <= '0; cnt <= '0; state <= S_CORN;
            ox <= '0; oy <= '0;
          end else if (ax[MB-1] || ay[MB-1]) begin
            ax <= ax >> 1; ay <= ay >> 1;
          end else if (!ax[MB-2] && !ay[MB-2]) begin
            ax <= ax << 1; ay <= ay << 1;
          end else begin
            sq_acc <= '0; sq_mcand <= {{(SB-MB){1'b0}}, ax}; sq_mplier <= ax;
            cnt <= '0; state <= S_SQX;
          end
        end
        S_SQX, S_SQY: begin
          if (sq_mplier[0]) sq_acc <= sq_acc + sq_mcand;
          sq_mcand <= sq_mcand << 1; sq_mplier <= sq_mplier >> 1;
          cnt <= cnt + 6'd1;
          if (cnt == 6'(MB-1)) begin
            cnt <= '0;
            if (state == S_SQX) begin
              sq_mcand <= {{(SB-MB){1'b0}}, ay}; sq_mplier <= ay; state <= S_SQY;
            end else begin
              rt_n <= sq_acc + (sq_mplier[0] ? sq_mcand : '0);
              rt_r <= '0; rt_bit <= {2'b01, {(SB-2){1'b0}}}; state <= S_ROOT;
            end
          end
        end
        S_ROOT: begin
          if (!rt_try[SB]) begin
            rt_n <= rt_try[SB-1:0];
            rt_r <= (rt_r >> 1) + rt_bit;
          end else rt_r <= rt_r >> 1;
          rt_bit <= rt_bit >> 2;
          if (rt_bit[0]) begin
            cnt <= '0;
            dv_num <= {2'b00, ax, {(UB-1){1'b0}}};
            dv_rem <= '0; state <= S_DIVX;
          end
        end
        S_DIVX, S_DIVY: begin
          if (cnt == 6'd0) begin
            dv_num <= dv_num + {{(MB+UB+1-RB){1'b0}}, rt_r[RB:1]};
            cnt <= 6'd1;
          end else begin
            dv_num <= dv_num << 1;
            if (dv_shift >= dv_div) begin
              dv_rem <= dv_shift - dv_div; dv_q <= {dv_q[UB-2:0], 1'b1};
            end else begin
              dv_rem <= dv_shift; dv_q <= {dv_q[UB-2:0], 1'b0};
            end
            cnt <= cnt + 6'd1;
            if (cnt == 6'(MB+UB+1)) begin
              cnt <= '0; dv_rem <= '0;
              if (state == S_DIVX) begin
                qx <= {dv_q[UB-2:0], dv_shift >= dv_div};
                dv_num <= {2'b00, ay, {(UB-1){1'b0}}}; state <= S_DIVY;
              end else begin
                ml_acc <= {{(PB-SS){1'b0}}, 1'b1, {(SS-1){1'b0}}};
                ml_a <= {dv_q[UB-2:0], dv_shift >= dv_div};
                ml_w <= width_reg; state <= S_MULX;
              end
            end
          end
        end
        S_MULX, S_MULY: begin
          ml_acc <= ml_sum;
          ml_w <= ml_w >> 1; cnt <= cnt + 6'd1;
          if (cnt == 6'(WB-1)) begin
            cnt <= '0;
            if (state == S_MULX) begin
              ox <= {1'b0, ml_sum[PB-1:SS]};
              ml_acc <= {{(PB-SS){1'b0}}, 1'b1, {(SS-1){1'b0}}};
              ml_a <= qx; ml_w <= width_reg; state <= S_MULY;
            end else begin
              oy <= {1'b0, ml_sum[PB-1:SS]};
              state <= S_CORN;
            end
          end
        end
        S_CORN: begin
          // ox is |offset| from uy (sign neg_y), oy from ux (sign neg_x).
          if (phase == 2'd1) begin
            corner0_x <= sat_add(prev_x, ox, !neg_y); corner0_y <= sat_add(prev_y, oy, neg_x);
            corner1_x <= sat_add(prev_x, ox, neg_y); corner1_y <= sat_add(prev_y, oy, !neg_x);
            first0_x <= sat_add(prev_x, ox, !neg_y); first0_y <= sat_add(prev_y, oy, neg_x);
            first1_x <= sat_add(prev_x, ox, neg_y); first1_y <= sat_add(prev_y, oy, !neg_x);
          end else begin
            corner0_x <= end3_x; corner0_y <= end3_y;
            corner1_x <= end2_x; corner1_y <= end2_y;
          end
          corner2_x <= sat_add(cur_x, ox, neg_y); corner2_y <= sat_add(cur_y, oy, !neg_x);
          corner3_x <= sat_add(cur_x, ox, !neg_y); corner3_y <= sat_add(cur_y, oy, neg_x);
          end2_x <= sat_add(cur_x, ox, neg_y); end2_y <= sat_add(cur_y, oy, !neg_x);
          end3_x <= sat_add(cur_x, ox, !neg_y); end3_y <= sat_add(cur_y, oy, neg_x);
          prev_x <= cur_x; prev_y <= cur_y; phase <= 2'd2;
          last_quad <= 1'b0; out_valid <= 1'b1;
          state <= S_EMIT1;
        end
        S_EMIT1: begin
          if (out_ready) begin
            if (fin) begin
              corner0_x <= end3_x; corner0_y <= end3_y;
              corner1_x <= end2_x; corner1_y <= end2_y;
              corner2_x <= first1_x; corner2_y <= first1_y;
              corner3_x <= first0_x; corner3_y <= first0_y;
              last_quad <= 1'b1; out_valid <= 1'b1; phase <= 2'd0;
              state <= S_EMIT2;
            end else state <= S_IDLE;
          end
        end
        S_EMIT2: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT1 || state == S_EMIT2) |-> out_valid) else $error("emit without valid");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("input ready while busy");
  a_close_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT2) |-> last_quad) else $error("closing quad not marked");

endmodule
